// ----- rtl/core/hsprn_pkg.sv -----
// shared types and constants for the serial print receiver
// payload structs, register indexes and byte classification helpers
// no dependencies
`default_nettype none

package hsprn_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_DEVICE_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS    = 1'b1;

  localparam logic [7:0]  OWN_CODE_RESET  = 8'h0f;
  localparam logic [15:0] TICKS_RESET     = 16'd1000;

  localparam logic [7:0] STROBE_MS = 8'd30;
  localparam logic [7:0] GAP_MS    = 8'd2;
  localparam logic [7:0] PULSE_MS  = 8'd9;
  localparam logic [7:0] MS_MAX    = 8'hff;

  localparam logic [7:0] CHR_ETX   = 8'h03;
  localparam logic [7:0] CHR_SO    = 8'h0e;
  localparam logic [7:0] CHR_SI    = 8'h0f;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  typedef struct packed {
    logic busy_level;
    logic data_level;
    logic strobe_level;
    logic select_level;
  } in_item_t;

  typedef struct packed {
    logic       ack_level;
    logic       char_valid;
    logic [7:0] char_code;
  } out_item_t;

  // codes after which the idle byte transfer is enabled
  function automatic logic is_listed_code(input logic [7:0] c);
    return (c == 8'h00) || (c == 8'hff) || (c == 8'h0f) || (c == 8'h21) || (c == 8'h45);
  endfunction

  // control bytes swallowed by the filter
  function automatic logic is_ctrl_code(input logic [7:0] c);
    return (c == CHR_ETX) || (c == CHR_SO) || (c == CHR_SI);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/handshake_serial_print_receiver.sv -----
// serial print receiver: one pin sample per transfer, one result per sample
// a sample passes through the input register and then the result register before
// its result is offered; throughput 1 sample per cycle while out_ready is held high
// the input register and the result register form a two-stage pipeline with stall
// rst_n synchronous active low: idle phase, timer and shifter cleared, registers
// own_device_code = 0x0f and ticks_per_ms = 1000, no item in flight
// uses hsprn_pkg
`default_nettype none

module handshake_serial_print_receiver
  import hsprn_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // sample channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  // register writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_STROBE   = 3'd1,
    PH_CODE_BIT = 3'd2,
    PH_BIT_GAP  = 3'd3,
    PH_BUSY_LOW = 3'd4,
    PH_ACK      = 3'd5,
    PH_MISMATCH = 3'd6
  } phase_t;

  // configuration
  logic [7:0]  own_code_r;
  logic [15:0] ticks_r;

  // pipeline control
  logic        s1_valid_r;
  in_item_t    s1_data_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic        advance;

  // receiver state
  phase_t      phase_r,        phase_nxt;
  logic [7:0]  shift_r,        shift_nxt;
  logic [2:0]  bit_cnt_r,      bit_cnt_nxt;
  logic [7:0]  acc_code_r,     acc_code_nxt;
  logic        ack_r,          ack_nxt;
  logic        last_busy_r,    last_busy_nxt;
  logic        last_strobe_r,  last_strobe_nxt;
  logic        ctrl_pend_r,    ctrl_pend_nxt;
  logic [15:0] sub_ms_r,       sub_ms_nxt;
  logic [7:0]  elapsed_r,      elapsed_nxt;

  logic        restart;
  logic        byte_full;
  logic        emit;
  logic [7:0]  emit_code;
  logic [16:0] sub_inc;

  // a sample moves on when the result register is free or being emptied
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // per-sample next state, evaluated on the sample held in the input register
  always_comb begin
    phase_nxt       = phase_r;
    shift_nxt       = shift_r;
    bit_cnt_nxt     = bit_cnt_r;
    acc_code_nxt    = acc_code_r;
    ack_nxt         = ack_r;
    last_busy_nxt   = last_busy_r;
    last_strobe_nxt = last_strobe_r;
    ctrl_pend_nxt   = ctrl_pend_r;
    restart         = 1'b0;
    byte_full       = 1'b0;
    emit            = 1'b0;
    emit_code       = 8'h00;
    sub_inc         = {1'b0, sub_ms_r} + 17'd1;

    case (phase_r)
      PH_IDLE: begin
        // strobe high starts timing the strobe width
        if (s1_data_r.strobe_level) begin
          restart     = 1'b1;
          phase_nxt   = PH_STROBE;
          shift_nxt   = 8'h00;
          bit_cnt_nxt = 3'd0;
        end
      end
      PH_STROBE: begin
        if (s1_data_r.strobe_level) begin
          if (elapsed_r > STROBE_MS) begin
            phase_nxt = PH_CODE_BIT;
            ack_nxt   = 1'b1;
          end
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_CODE_BIT: begin
        if (s1_data_r.busy_level) begin
          // lsb first shift of one device-code bit
          shift_nxt   = {s1_data_r.data_level, shift_r[7:1]};
          bit_cnt_nxt = bit_cnt_r + 3'd1;
          ack_nxt     = 1'b0;
          if (bit_cnt_nxt == 3'd0) begin
            acc_code_nxt = shift_nxt;
            if (shift_nxt == own_code_r) begin
              phase_nxt = PH_BUSY_LOW;
            end else begin
              phase_nxt = PH_MISMATCH;
              restart   = 1'b1;
            end
            shift_nxt   = 8'h00;
            bit_cnt_nxt = 3'd0;
          end else begin
            phase_nxt = PH_BIT_GAP;
            restart   = 1'b1;
          end
        end
      end
      PH_BIT_GAP: begin
        if (elapsed_r > GAP_MS) begin
          phase_nxt = PH_CODE_BIT;
          ack_nxt   = 1'b1;
        end
      end
      PH_BUSY_LOW: begin
        // code matched: answer with an ack pulse once busy falls
        if (!s1_data_r.busy_level) begin
          ack_nxt     = 1'b1;
          phase_nxt   = PH_ACK;
          restart     = 1'b1;
          shift_nxt   = 8'h00;
          bit_cnt_nxt = 3'd0;
        end
      end
      PH_ACK: begin
        if (elapsed_r > PULSE_MS) begin
          ack_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          restart   = 1'b1;
        end
      end
      PH_MISMATCH: begin
        if (elapsed_r > GAP_MS && s1_data_r.busy_level) begin
          ack_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // idle byte transfer, runs on the phase this sample ends in
    if (phase_nxt == PH_IDLE && is_listed_code(acc_code_nxt)) begin
      // ack timeout with both host lines quiet
      if (!s1_data_r.busy_level && !last_busy_r && !s1_data_r.strobe_level &&
          !last_strobe_r && ack_nxt && elapsed_r > GAP_MS) begin
        restart = 1'b1;
        ack_nxt = 1'b0;
      end
      if (s1_data_r.select_level) begin
        shift_nxt   = 8'h00;
        bit_cnt_nxt = 3'd0;
      end
      if (s1_data_r.busy_level != last_busy_r) begin
        if (ack_nxt) begin
          ack_nxt = 1'b0;
        end else begin
          ack_nxt = 1'b1;
          restart = 1'b1;
        end
        if (s1_data_r.busy_level) begin
          shift_nxt   = {s1_data_r.data_level, shift_nxt[7:1]};
          bit_cnt_nxt = bit_cnt_nxt + 3'd1;
          byte_full   = (bit_cnt_nxt == 3'd0);
          if (byte_full) begin
            // control filter
            if (ctrl_pend_r && shift_nxt == CHR_SPACE) begin
              ctrl_pend_nxt = 1'b0;
              emit          = 1'b1;
            end else if (is_ctrl_code(shift_nxt)) begin
              ctrl_pend_nxt = 1'b1;
            end else begin
              emit = 1'b1;
            end
            emit_code   = emit ? shift_nxt : 8'h00;
            shift_nxt   = 8'h00;
            bit_cnt_nxt = 3'd0;
          end
        end
      end
      last_busy_nxt   = s1_data_r.busy_level;
      last_strobe_nxt = s1_data_r.strobe_level;
    end

    // millisecond timer: prescaler then saturating ms count
    if (restart) begin
      sub_ms_nxt  = 16'd0;
      elapsed_nxt = 8'd0;
    end else if (sub_inc >= {1'b0, ticks_r}) begin
      sub_ms_nxt  = 16'd0;
      elapsed_nxt = (elapsed_r == MS_MAX) ? elapsed_r : elapsed_r + 8'd1;
    end else begin
      sub_ms_nxt  = sub_inc[15:0];
      elapsed_nxt = elapsed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_code_r    <= OWN_CODE_RESET;
      ticks_r       <= TICKS_RESET;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      phase_r       <= PH_IDLE;
      shift_r       <= 8'h00;
      bit_cnt_r     <= 3'd0;
      acc_code_r    <= 8'h00;
      ack_r         <= 1'b0;
      last_busy_r   <= 1'b0;
      last_strobe_r <= 1'b0;
      ctrl_pend_r   <= 1'b0;
      sub_ms_r      <= 16'd0;
      elapsed_r     <= 8'd0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_DEVICE_CODE: own_code_r <= cfg_wdata[7:0];
          CFG_TICKS_PER_MS:    ticks_r    <= cfg_wdata;
          default: ;
        endcase
      end

      // input register
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end

      // result register
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // receiver state moves once per processed sample
      if (advance) begin
        phase_r       <= phase_nxt;
        shift_r       <= shift_nxt;
        bit_cnt_r     <= bit_cnt_nxt;
        acc_code_r    <= acc_code_nxt;
        ack_r         <= ack_nxt;
        last_busy_r   <= last_busy_nxt;
        last_strobe_r <= last_strobe_nxt;
        ctrl_pend_r   <= ctrl_pend_nxt;
        sub_ms_r      <= sub_ms_nxt;
        elapsed_r     <= elapsed_nxt;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r.ack_level  <= ack_nxt;
      out_data_r.char_valid <= emit;
      out_data_r.char_code  <= emit_code;
    end
  end

  // control bytes are never delivered as characters
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.char_valid) |->
      !(out_data.char_code == CHR_ETX || out_data.char_code == CHR_SO ||
        out_data.char_code == CHR_SI))
    else $error("control byte delivered");

  // an empty result register never blocks the input side
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !s1_valid_r) |-> in_ready)
    else $error("input stalled with empty pipeline");

  // the ms count only steps up by one or restarts
  assert property (@(posedge clk) disable iff (!rst_n)
    (elapsed_r != $past(elapsed_r)) |->
      (elapsed_r == 8'd0 || elapsed_r == $past(elapsed_r) + 8'd1))
    else $error("ms timer jumped");

  // receiver state is frozen while the pipeline is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(phase_r) && $stable(shift_r) && $stable(ack_r)))
    else $error("state changed without a processed sample");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking bench for the serial print receiver: random pin samples against a cycle model
// needs hsprn_pkg and handshake_serial_print_receiver from the rtl tree, nothing else
`timescale 1ns / 100ps

module testbench
  import hsprn_pkg::*;
;

  localparam int unsigned LATENCY        = 2;
  localparam int unsigned ITEM_TARGET    = 850;
  localparam int unsigned LIMIT_CYCLES   = 400000;
  localparam int unsigned HOLDOFF_CYCLES = 300;

  // codes after which busy edges clock bytes in while idle
  localparam logic [4:0][7:0] ENABLE_CODES = {8'h45, 8'h21, 8'h0f, 8'hff, 8'h00};
  // bytes the control filter cares about
  localparam logic [3:0][7:0] FILTER_BYTES = {CHR_SPACE, CHR_SI, CHR_SO, CHR_ETX};
  // opening byte run: plain, control, space after control, extremes
  localparam logic [9:0][7:0] OPENING_BYTES = {8'h7f, 8'h00, 8'hff, CHR_SPACE, 8'h41,
                                               CHR_SI, CHR_SO, CHR_SPACE, CHR_ETX, 8'h41};

  typedef enum logic [2:0] {
    PH_IDLE, PH_STROBE, PH_CODE_BIT, PH_BIT_GAP, PH_WAIT_LOW, PH_ACK_PULSE, PH_MISMATCH
  } prn_phase_t;

  logic clk;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  handshake_serial_print_receiver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // bookkeeping shared between stimulus, driver and monitor
  // ---------------------------------------------------------------------------
  in_item_t    pin_samples[$];        // samples waiting to be offered
  out_item_t   pending_responses[$];  // predicted responses, oldest first
  int unsigned samples_queued    = 0;
  int unsigned responses_checked = 0;
  int unsigned fail_count        = 0;
  int unsigned chars_out         = 0;
  int unsigned codes_sent        = 0;
  int unsigned reg_writes        = 0;
  int unsigned cycle_count       = 0;
  int unsigned holdoff_reqs      = 0;  // bumped by stimulus, served by the ready process
  int unsigned holdoffs_done     = 0;

  // register mirror, follows every write the stimulus makes
  logic [7:0]  own_code = OWN_CODE_RESET;
  logic [15:0] ms_ticks = TICKS_RESET;

  // ---------------------------------------------------------------------------
  // printer model: phase machine, shifter, byte filter and millisecond timer
  // ---------------------------------------------------------------------------
  prn_phase_t  pr_phase;
  logic [7:0]  pr_shift;
  logic [2:0]  pr_nbits;
  logic [7:0]  pr_code;       // last code seen during a code transfer
  logic        pr_ack;
  logic        pr_last_busy;
  logic        pr_last_strobe;
  logic        pr_ctrl;       // a control byte came and no space since
  logic [15:0] pr_sub;
  logic [7:0]  pr_ms;

  function automatic logic code_enables_printing(logic [7:0] c);
    for (int i = 0; i < 5; i++)
      if (c == ENABLE_CODES[i]) return 1'b1;
    return 1'b0;
  endfunction

  // lsb first; true once the eighth bit is in
  function automatic logic shift_bit(logic b);
    pr_shift = {b, pr_shift[7:1]};
    pr_nbits = pr_nbits + 3'd1;
    return pr_nbits == 3'd0;
  endfunction

  function automatic out_item_t printer_response(in_item_t s);
    out_item_t   r;
    logic        restart;
    logic [16:0] nxt;
    r = '0;
    restart = 1'b0;

    case (pr_phase)
      PH_IDLE: begin
        if (s.strobe_level) begin
          restart = 1'b1;
          pr_phase = PH_STROBE;
          pr_shift = '0;
          pr_nbits = '0;
        end
      end
      PH_STROBE: begin
        if (!s.strobe_level) begin
          pr_phase = PH_IDLE;
        end else if (pr_ms > STROBE_MS) begin
          pr_phase = PH_CODE_BIT;
          pr_ack = 1'b1;
        end
      end
      PH_CODE_BIT: begin
        if (s.busy_level) begin
          pr_ack = 1'b0;
          if (shift_bit(s.data_level)) begin
            pr_code = pr_shift;
            if (pr_shift == own_code) begin
              pr_phase = PH_WAIT_LOW;
            end else begin
              pr_phase = PH_MISMATCH;
              restart = 1'b1;
            end
            pr_shift = '0;
            pr_nbits = '0;
          end else begin
            pr_phase = PH_BIT_GAP;
            restart = 1'b1;
          end
        end
      end
      PH_BIT_GAP: begin
        if (pr_ms > GAP_MS) begin
          pr_phase = PH_CODE_BIT;
          pr_ack = 1'b1;
        end
      end
      PH_WAIT_LOW: begin
        if (!s.busy_level) begin
          pr_ack = 1'b1;
          pr_phase = PH_ACK_PULSE;
          restart = 1'b1;
          pr_shift = '0;
          pr_nbits = '0;
        end
      end
      PH_ACK_PULSE: begin
        if (pr_ms > PULSE_MS) begin
          pr_ack = 1'b0;
          pr_phase = PH_IDLE;
          restart = 1'b1;
        end
      end
      PH_MISMATCH: begin
        if (pr_ms > GAP_MS && s.busy_level) begin
          pr_ack = 1'b0;
          pr_phase = PH_IDLE;
        end
      end
      default: pr_phase = PH_IDLE;
    endcase

    // idle byte reception, only after an enabling code
    if (pr_phase == PH_IDLE && code_enables_printing(pr_code)) begin
      // ack timeout: lines quiet, ack left high too long
      if (!s.busy_level && !pr_last_busy && !s.strobe_level && !pr_last_strobe &&
          pr_ack && pr_ms > GAP_MS) begin
        restart = 1'b1;
        pr_ack = 1'b0;
      end
      if (s.select_level) begin
        pr_shift = '0;
        pr_nbits = '0;
      end
      if (s.busy_level != pr_last_busy) begin
        if (pr_ack) begin
          pr_ack = 1'b0;
        end else begin
          pr_ack = 1'b1;
          restart = 1'b1;
        end
        if (s.busy_level) begin
          if (shift_bit(s.data_level)) begin
            if (pr_ctrl && pr_shift == CHR_SPACE) begin
              pr_ctrl = 1'b0;
              r.char_valid = 1'b1;
            end else if (pr_shift inside {CHR_ETX, CHR_SO, CHR_SI}) begin
              pr_ctrl = 1'b1;
            end else begin
              r.char_valid = 1'b1;
            end
            if (r.char_valid) r.char_code = pr_shift;
            pr_shift = '0;
            pr_nbits = '0;
          end
        end
      end
      pr_last_busy = s.busy_level;
      pr_last_strobe = s.strobe_level;
    end

    // prescaled ms timer; zero ticks acts as one
    if (restart) begin
      pr_sub = '0;
      pr_ms = '0;
    end else begin
      nxt = {1'b0, pr_sub} + 17'd1;
      if (nxt >= {1'b0, ms_ticks}) begin
        pr_sub = '0;
        if (pr_ms != MS_MAX) pr_ms = pr_ms + 8'd1;
      end else begin
        pr_sub = nxt[15:0];
      end
    end

    r.ack_level = pr_ack;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued samples, random gap after each transfer
  // ---------------------------------------------------------------------------
  int unsigned send_wait = 0;
  logic        send_calm = 1'b0;  // stretch with no gaps

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      send_wait <= 0;
    end else if (!in_valid || in_ready) begin
      // slot is free now or the current sample transfers at this edge
      if (send_wait != 0) begin
        in_valid  <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (pin_samples.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pin_samples.pop_front();
        if ($urandom_range(0, 39) == 0) send_calm <= ~send_calm;
        send_wait <= send_calm ? 0 : $urandom_range(0, 17);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side ready: random stall per transfer, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  int unsigned ready_wait   = 0;
  int unsigned holdoff_left = 0;
  logic        recv_calm    = 1'b0;

  always @(posedge clk) begin : ready_gen
    int unsigned stall;
    if (!rst_n) begin
      out_ready     <= 1'b0;
      ready_wait    <= 0;
      holdoff_left  <= 0;
      holdoffs_done <= 0;
    end else if (holdoffs_done != holdoff_reqs) begin
      holdoffs_done <= holdoffs_done + 1;
      holdoff_left  <= HOLDOFF_CYCLES;
      out_ready     <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready    <= 1'b0;
    end else if (out_valid && out_ready) begin
      if ($urandom_range(0, 39) == 0) recv_calm <= ~recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 17);
      ready_wait <= stall;
      out_ready  <= (stall == 0);
    end else if (ready_wait != 0) begin
      ready_wait <= ready_wait - 1;
      out_ready  <= (ready_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each input transfer, check each result transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      pr_phase       = PH_IDLE;
      pr_shift       = '0;
      pr_nbits       = '0;
      pr_code        = '0;
      pr_ack         = 1'b0;
      pr_last_busy   = 1'b0;
      pr_last_strobe = 1'b0;
      pr_ctrl        = 1'b0;
      pr_sub         = '0;
      pr_ms          = '0;
    end else begin
      // predict first so the order of the two transfers never matters
      if (in_valid && in_ready)
        pending_responses.push_back(printer_response(in_data));
      if (out_valid && out_ready) begin
        responses_checked++;
        if (out_data.char_valid) chars_out++;
        if (pending_responses.size() == 0) begin
          $error("result transfer with nothing predicted: ack %0d valid %0d code %02h",
                 out_data.ack_level, out_data.char_valid, out_data.char_code);
          fail_count++;
        end else begin
          want = pending_responses.pop_front();
          if (out_data.ack_level !== want.ack_level) begin
            $error("ack_level: expected %0d, got %0d", want.ack_level, out_data.ack_level);
            fail_count++;
          end
          if (out_data.char_valid !== want.char_valid) begin
            $error("char_valid: expected %0d, got %0d", want.char_valid, out_data.char_valid);
            fail_count++;
          end
          if (out_data.char_code !== want.char_code) begin
            $error("char_code: expected %02h, got %02h", want.char_code, out_data.char_code);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d of %0d results checked",
               cycle_count, responses_checked, samples_queued);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_sample(logic busy, logic data, logic strobe, logic sel);
    in_item_t s;
    s.busy_level   = busy;
    s.data_level   = data;
    s.strobe_level = strobe;
    s.select_level = sel;
    pin_samples.push_back(s);
    samples_queued++;
  endfunction

  // register write, only called with nothing in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OWN_DEVICE_CODE) own_code = val[7:0];
    else ms_ticks = val;
    reg_writes++;
  endtask

  // sender pause: hold everything back until every result is in
  task automatic wait_quiet();
    do @(posedge clk); while (responses_checked != samples_queued);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // one byte in idle mode: data with busy rising, busy low between bits
  task automatic send_byte(logic [7:0] b, bit noisy);
    int i;
    for (i = 0; i < 8; i++) begin
      repeat (1 + (noisy ? $urandom_range(0, 2) : $urandom_range(0, 1)))
        queue_sample(1'b1, b[i], 1'b0, noisy && $urandom_range(0, 15) == 0);
      repeat (1 + $urandom_range(0, 1))
        queue_sample(1'b0, 1'($urandom_range(0, 1)), 1'b0,
                     noisy && $urandom_range(0, 15) == 0);
    end
  endtask

  // device code transfer: long strobe, eight acknowledged bits, then the
  // ack pulse on a match or the mismatch wait; a broken one cuts timings short
  task automatic send_code(logic [7:0] code, bit broken);
    int unsigned t, n;
    int i;
    logic lead;
    t = (ms_ticks == 0) ? 1 : ms_ticks;
    // busy level left in the idle edge tracker; high makes the ack timeout fire later
    lead = 1'($urandom_range(0, 1));
    queue_sample(lead, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
    if (broken && $urandom_range(0, 1)) n = $urandom_range(1, 31 * t);
    else n = 31 * t + 3 + $urandom_range(0, 3);
    repeat (n)
      queue_sample(1'b0, 1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1)));
    for (i = 0; i < 8; i++) begin
      queue_sample(1'b1, code[i], 1'b0, 1'($urandom_range(0, 1)));
      if (broken && $urandom_range(0, 3) == 0) n = $urandom_range(0, 3 * t);
      else n = 3 * t + 3 + $urandom_range(0, 2);
      if (i < 7) repeat (n)
        queue_sample(1'b0, 1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)));
    end
    if (code == own_code) begin
      n = 10 * t + 4 + $urandom_range(0, 2);
    end else begin
      repeat (3 * t + 3 + $urandom_range(0, 2))
        queue_sample(1'b0, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      queue_sample(1'b1, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      n = 1;
    end
    // quiet tail long enough for an ack timeout
    repeat (n + 3 * t + 3 + $urandom_range(0, 3))
      queue_sample(1'b0, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
    codes_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]  pick;
    int unsigned phase_start;
    int          k;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: the last received code resets to 0x00, which already enables idle printing
    for (k = 0; k < 10; k++) send_byte(OPENING_BYTES[k], 1'b0);
    // long receiver hold-off while the opening bytes keep coming
    holdoff_reqs <= holdoff_reqs + 1;
    // partial byte wiped by select, then a clean byte
    for (k = 0; k < 3; k++) begin
      queue_sample(1'b1, 1'b1, 1'b0, 1'b0);
      queue_sample(1'b0, 1'b0, 1'b0, 1'b0);
    end
    queue_sample(1'b0, 1'b0, 1'b0, 1'b1);
    send_byte(8'h5a, 1'b0);

    // fast timer: matching code, mismatch to an unlisted code, aborted strobe,
    // mismatch to a listed code
    wait_quiet();
    write_reg(CFG_TICKS_PER_MS, 16'd1);
    write_reg(CFG_OWN_DEVICE_CODE, 16'h0021);
    send_code(8'h21, 1'b0);
    send_byte(8'h48, 1'b0);
    send_byte(CHR_SPACE, 1'b0);
    send_code(8'h5a, 1'b0);
    send_byte(8'h41, 1'b0);
    repeat (10) queue_sample(1'b0, 1'b0, 1'b1, 1'b0);
    queue_sample(1'b0, 1'b0, 1'b0, 1'b0);
    send_code(8'h45, 1'b0);
    send_byte(8'h33, 1'b0);

    // zero ticks runs like one, top code value
    wait_quiet();
    write_reg(CFG_TICKS_PER_MS, 16'd0);
    write_reg(CFG_OWN_DEVICE_CODE, 16'h00ff);
    send_code(8'hff, 1'b0);
    send_byte(CHR_SI, 1'b0);
    send_byte(CHR_SPACE, 1'b0);

    // slowest timer, bottom code value; only idle bytes fit here
    wait_quiet();
    write_reg(CFG_TICKS_PER_MS, 16'hffff);
    write_reg(CFG_OWN_DEVICE_CODE, 16'h0000);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);

    // random phases: mostly well formed transfers, some broken ones and noise
    k = 0;
    while (samples_queued < ITEM_TARGET) begin
      wait_quiet();
      if ($urandom_range(0, 3) == 0) pick = 8'($urandom_range(0, 255));
      else pick = ENABLE_CODES[3'($urandom_range(0, 4))];
      write_reg(CFG_OWN_DEVICE_CODE, {8'h00, pick});
      write_reg(CFG_TICKS_PER_MS, 16'($urandom_range(1, 3)));
      // one long receiver hold-off while the sender keeps offering
      if (k == 1) holdoff_reqs <= holdoff_reqs + 1;
      phase_start = samples_queued;
      while (samples_queued - phase_start < 120 && samples_queued < ITEM_TARGET) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            if ($urandom_range(0, 1)) pick = own_code;
            else if ($urandom_range(0, 1)) pick = ENABLE_CODES[3'($urandom_range(0, 4))];
            else pick = 8'($urandom_range(0, 255));
            send_code(pick, $urandom_range(0, 4) == 0);
          end
          8: begin
            repeat ($urandom_range(1, 6))
              queue_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
          end
          default: begin
            if ($urandom_range(0, 3) == 0) pick = FILTER_BYTES[2'($urandom_range(0, 3))];
            else pick = 8'($urandom_range(0, 255));
            send_byte(pick, $urandom_range(0, 4) == 0);
          end
        endcase
      end
      k++;
    end

    wait_quiet();
    $display("run covered %0d pin samples, %0d code transfers, %0d register writes",
             samples_queued, codes_sent, reg_writes);
    $display("%0d results checked, %0d characters printed, %0d mismatches",
             responses_checked, chars_out, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/hsprn_pkg.sv
rtl/core/handshake_serial_print_receiver.sv
tb/testbench.sv
